// ===== src/icvh_pkg.sv =====
// Package for the incremental convex hull block.
// Holds command and status codes and the orientation unit status word.
// No dependencies.
package icvh_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SEED  = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic done;
    logic outside;
  } orient_stat_t;

endpackage

// ===== src/icvh_if.sv =====
// Valid/ready channel interfaces for the convex hull block.
// Input word carries a command and a point; output word carries a face.
// No dependencies.
interface icvh_in_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source(output valid, func, point_x, point_y, point_z, input ready);
  modport sink(input valid, func, point_x, point_y, point_z, output ready);
endinterface

interface icvh_out_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;
  logic                         last;
  logic [1:0]                   status;

  modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 third_x, third_y, third_z, last, status, input ready);
  modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, last, status, output ready);
endinterface

// ===== src/incremental_convex_hull.sv =====
// Incremental 3D convex hull: face table and removed-face list in two memories.
// Status commands produce one status word; read returns the stored faces one word each.
// Add after seeding scans every stored face, then tests each removed/kept face pair
// and appends a face for each shared edge; commands are taken one word at a time.
// Reset clears counts, state and output valid; memory contents are not cleared.
module incremental_convex_hull #(
  parameter int MAX_FACES  = 64,
  parameter int COORD_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  icvh_in_if.sink    in_word,
  icvh_out_if.source out_word
);
  import icvh_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int VW = 3 * C;
  localparam int EW = 3 * VW;
  localparam int PW = C + 2;
  localparam int IW = $clog2(MAX_FACES);
  localparam int CW = $clog2(MAX_FACES + 1);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_SEED     = 15'h0002,
    S_ADD_ST   = 15'h0004,
    S_ADD_OR   = 15'h0008,
    S_SCAN_WT  = 15'h0010,
    S_SCAN_LD  = 15'h0020,
    S_SCAN_OR  = 15'h0040,
    S_PAIR_GRD = 15'h0080,
    S_PAIR_GLD = 15'h0100,
    S_PAIR_FRD = 15'h0200,
    S_PAIR_CHK = 15'h0400,
    S_PAIR_NXT = 15'h0800,
    S_RD_WT    = 15'h1000,
    S_RD_EM    = 15'h2000,
    S_EMIT     = 15'h4000
  } state_t;

  state_t          state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0]   fcount_r, fcount_nxt, kept_r, kept_nxt, gcnt_r, gcnt_nxt;
  logic [CW-1:0]   i_r, i_nxt, j_r, j_nxt, g_r, g_nxt;
  logic [2:0]      seedcnt_r, seedcnt_nxt, sk_r, sk_nxt;
  logic            ovf_r, ovf_nxt, start_r, start_nxt;
  logic [1:0]      st_r, st_nxt;
  logic [VW-1:0]   pt_r, pt_nxt;
  logic [VW-1:0]   seed_r [3];
  logic [VW-1:0]   seed_nxt [3];
  logic [3*PW-1:0] sum_r, sum_nxt;
  logic [EW-1:0]   cur_r, cur_nxt, gcur_r, gcur_nxt;
  logic [VW-1:0]   add_p_r, add_p_nxt, add_q_r, add_q_nxt, add_r_r, add_r_nxt;

  logic [EW-1:0]   face_mem [MAX_FACES];
  logic [EW-1:0]   gone_mem [MAX_FACES];
  logic [EW-1:0]   face_rdata, gone_rdata, face_wdata;
  logic [IW-1:0]   face_raddr, face_waddr, gone_waddr;
  logic            face_we, gone_we;

  logic            ov_r;
  logic [EW-1:0]   o_ent_r, ld_ent;
  logic            o_last_r, ld_last;
  logic [1:0]      o_st_r, ld_st;
  logic            load_out, out_free;

  logic [VW-1:0]   in_pt, or_a, or_b, or_c;
  logic [3*PW-1:0] or_p, pt_ext, seed_sum;
  logic            or_k4;
  orient_stat_t    ostat;

  function automatic logic in_face(input logic [VW-1:0] v, input logic [EW-1:0] f);
    return (v == f[0 +: VW]) || (v == f[VW +: VW]) || (v == f[2*VW +: VW]);
  endfunction

  assign in_pt    = {in_word.point_z, in_word.point_y, in_word.point_x};
  assign out_free = !ov_r || out_word.ready;
  assign in_word.ready = (state_r == S_IDLE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_ext[k*PW +: PW]   = PW'($signed(pt_r[k*C +: C]));
      seed_sum[k*PW +: PW] = PW'($signed(seed_r[0][k*C +: C]))
                           + PW'($signed(seed_r[1][k*C +: C]))
                           + PW'($signed(seed_r[2][k*C +: C]))
                           + PW'($signed(in_pt[k*C +: C]));
    end
  end

  always_comb begin
    if (state_r == S_ADD_OR) begin
      or_a  = add_p_r;
      or_b  = add_q_r;
      or_c  = add_r_r;
      or_p  = sum_r;
      or_k4 = 1'b1;
    end else begin
      or_a  = cur_r[0 +: VW];
      or_b  = cur_r[VW +: VW];
      or_c  = cur_r[2*VW +: VW];
      or_p  = pt_ext;
      or_k4 = 1'b0;
    end
  end

  icvh_orient #(.COORD_BITS(COORD_BITS)) u_orient (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .a     (or_a),
    .b     (or_b),
    .c     (or_c),
    .p     (or_p),
    .k4    (or_k4),
    .stat  (ostat)
  );

  assign face_raddr = (state_r == S_PAIR_FRD) ? j_r[IW-1:0] : i_r[IW-1:0];

  always_comb begin
    logic [CW-1:0] k_after;
    logic [CW-1:0] g_after;
    logic          ga_in, gb_in, gc_in;
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    fcount_nxt  = fcount_r;
    kept_nxt    = kept_r;
    gcnt_nxt    = gcnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    g_nxt       = g_r;
    seedcnt_nxt = seedcnt_r;
    sk_nxt      = sk_r;
    ovf_nxt     = ovf_r;
    start_nxt   = 1'b0;
    st_nxt      = st_r;
    pt_nxt      = pt_r;
    seed_nxt    = seed_r;
    sum_nxt     = sum_r;
    cur_nxt     = cur_r;
    gcur_nxt    = gcur_r;
    add_p_nxt   = add_p_r;
    add_q_nxt   = add_q_r;
    add_r_nxt   = add_r_r;
    face_we     = 1'b0;
    face_waddr  = kept_r[IW-1:0];
    face_wdata  = cur_r;
    gone_we     = 1'b0;
    gone_waddr  = gcnt_r[IW-1:0];
    load_out    = 1'b0;
    ld_ent      = '0;
    ld_last     = 1'b1;
    ld_st       = st_r;
    k_after     = kept_r + CW'(!ostat.outside);
    g_after     = gcnt_r + CW'(ostat.outside);
    ga_in       = in_face(gcur_r[0 +: VW], face_rdata);
    gb_in       = in_face(gcur_r[VW +: VW], face_rdata);
    gc_in       = in_face(gcur_r[2*VW +: VW], face_rdata);

    unique case (state_r)
      S_IDLE: begin
        if (in_word.valid) begin
          pt_nxt = in_pt;
          unique case (in_word.func)
            FUNC_CLEAR: begin
              fcount_nxt  = '0;
              gcnt_nxt    = '0;
              seedcnt_nxt = '0;
              sum_nxt     = '0;
              st_nxt      = ST_OK;
              state_nxt   = S_EMIT;
            end
            FUNC_READ: begin
              i_nxt = '0;
              if (fcount_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_RD_WT;
              end
            end
            FUNC_NOP: begin
              st_nxt    = ST_OK;
              state_nxt = S_EMIT;
            end
            FUNC_ADD: begin
              if (seedcnt_r < 3'd3) begin
                seed_nxt[seedcnt_r[1:0]] = in_pt;
                seedcnt_nxt = seedcnt_r + 3'd1;
                st_nxt      = ST_SEED;
                state_nxt   = S_EMIT;
              end else if (seedcnt_r == 3'd3) begin
                sum_nxt     = seed_sum;
                fcount_nxt  = '0;
                sk_nxt      = '0;
                seedcnt_nxt = 3'd4;
                state_nxt   = S_SEED;
              end else begin
                i_nxt    = '0;
                kept_nxt = '0;
                gcnt_nxt = '0;
                ovf_nxt  = 1'b0;
                st_nxt   = ST_OK;
                state_nxt = (fcount_r == '0) ? S_EMIT : S_SCAN_WT;
              end
            end
          endcase
        end
      end
      S_SEED: begin
        if (sk_r == 3'd4) begin
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          case (sk_r)
            3'd0: begin add_p_nxt = seed_r[0]; add_q_nxt = seed_r[1]; add_r_nxt = seed_r[2]; end
            3'd1: begin add_p_nxt = seed_r[1]; add_q_nxt = seed_r[2]; add_r_nxt = pt_r; end
            3'd2: begin add_p_nxt = seed_r[2]; add_q_nxt = pt_r; add_r_nxt = seed_r[0]; end
            default: begin add_p_nxt = pt_r; add_q_nxt = seed_r[0]; add_r_nxt = seed_r[1]; end
          endcase
          sk_nxt    = sk_r + 3'd1;
          ret_nxt   = S_SEED;
          state_nxt = S_ADD_ST;
        end
      end
      S_ADD_ST: begin
        if (fcount_r >= CW'(MAX_FACES)) begin
          ovf_nxt   = 1'b1;
          state_nxt = ret_r;
        end else begin
          start_nxt = 1'b1;
          state_nxt = S_ADD_OR;
        end
      end
      S_ADD_OR: begin
        if (ostat.done) begin
          face_we    = 1'b1;
          face_waddr = fcount_r[IW-1:0];
          face_wdata = ostat.outside ? {add_q_r, add_r_r, add_p_r}
                                     : {add_r_r, add_q_r, add_p_r};
          fcount_nxt = fcount_r + CW'(1);
          state_nxt  = ret_r;
        end
      end
      S_SCAN_WT: state_nxt = S_SCAN_LD;
      S_SCAN_LD: begin
        cur_nxt   = face_rdata;
        start_nxt = 1'b1;
        state_nxt = S_SCAN_OR;
      end
      S_SCAN_OR: begin
        if (ostat.done) begin
          if (ostat.outside) begin
            gone_we = 1'b1;
          end else begin
            face_we = 1'b1;
          end
          kept_nxt = k_after;
          gcnt_nxt = g_after;
          i_nxt    = i_r + CW'(1);
          if (CW'(i_r + CW'(1)) == fcount_r) begin
            fcount_nxt = k_after;
            g_nxt      = '0;
            state_nxt  = (k_after == '0 || g_after == '0) ? S_EMIT : S_PAIR_GRD;
          end else begin
            state_nxt = S_SCAN_WT;
          end
        end
      end
      S_PAIR_GRD: state_nxt = S_PAIR_GLD;
      S_PAIR_GLD: begin
        gcur_nxt  = gone_rdata;
        j_nxt     = '0;
        state_nxt = S_PAIR_FRD;
      end
      S_PAIR_FRD: state_nxt = S_PAIR_CHK;
      S_PAIR_CHK: begin
        add_p_nxt = pt_r;
        ret_nxt   = S_PAIR_NXT;
        state_nxt = S_ADD_ST;
        if (ga_in && gb_in) begin
          add_q_nxt = gcur_r[0 +: VW];
          add_r_nxt = gcur_r[VW +: VW];
        end else if (gb_in && gc_in) begin
          add_q_nxt = gcur_r[VW +: VW];
          add_r_nxt = gcur_r[2*VW +: VW];
        end else if (gc_in && ga_in) begin
          add_q_nxt = gcur_r[2*VW +: VW];
          add_r_nxt = gcur_r[0 +: VW];
        end else begin
          state_nxt = S_PAIR_NXT;
        end
      end
      S_PAIR_NXT: begin
        if (CW'(j_r + CW'(1)) == kept_r) begin
          if (CW'(g_r + CW'(1)) == gcnt_r) begin
            st_nxt    = ovf_r ? ST_OVF : ST_OK;
            state_nxt = S_EMIT;
          end else begin
            g_nxt     = g_r + CW'(1);
            state_nxt = S_PAIR_GRD;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_PAIR_FRD;
        end
      end
      S_RD_WT: state_nxt = S_RD_EM;
      S_RD_EM: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_ent   = face_rdata;
          ld_st    = ST_OK;
          ld_last  = (CW'(i_r + CW'(1)) == fcount_r);
          i_nxt    = i_r + CW'(1);
          state_nxt = ld_last ? S_IDLE : S_RD_WT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      fcount_r  <= '0;
      kept_r    <= '0;
      gcnt_r    <= '0;
      i_r       <= '0;
      j_r       <= '0;
      g_r       <= '0;
      seedcnt_r <= '0;
      sk_r      <= '0;
      ovf_r     <= 1'b0;
      start_r   <= 1'b0;
      st_r      <= ST_OK;
      sum_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      fcount_r  <= fcount_nxt;
      kept_r    <= kept_nxt;
      gcnt_r    <= gcnt_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      g_r       <= g_nxt;
      seedcnt_r <= seedcnt_nxt;
      sk_r      <= sk_nxt;
      ovf_r     <= ovf_nxt;
      start_r   <= start_nxt;
      st_r      <= st_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r    <= pt_nxt;
    seed_r  <= seed_nxt;
    cur_r   <= cur_nxt;
    gcur_r  <= gcur_nxt;
    add_p_r <= add_p_nxt;
    add_q_r <= add_q_nxt;
    add_r_r <= add_r_nxt;
  end

  always_ff @(posedge clk) begin
    if (face_we) begin
      face_mem[face_waddr] <= face_wdata;
    end
    face_rdata <= face_mem[face_raddr];
  end

  always_ff @(posedge clk) begin
    if (gone_we) begin
      gone_mem[gone_waddr] <= cur_r;
    end
    gone_rdata <= gone_mem[g_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
    end else if (out_word.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_ent_r  <= ld_ent;
      o_last_r <= ld_last;
      o_st_r   <= ld_st;
    end
  end

  assign out_word.valid    = ov_r;
  assign out_word.first_x  = o_ent_r[0*C +: C];
  assign out_word.first_y  = o_ent_r[1*C +: C];
  assign out_word.first_z  = o_ent_r[2*C +: C];
  assign out_word.second_x = o_ent_r[3*C +: C];
  assign out_word.second_y = o_ent_r[4*C +: C];
  assign out_word.second_z = o_ent_r[5*C +: C];
  assign out_word.third_x  = o_ent_r[6*C +: C];
  assign out_word.third_y  = o_ent_r[7*C +: C];
  assign out_word.third_z  = o_ent_r[8*C +: C];
  assign out_word.last     = o_last_r;
  assign out_word.status   = o_st_r;

endmodule

// ===== src/icvh_orient.sv =====
// Sequential orientation test: sign of dot(cross(b-a, c-a), p - k*a), k = 1 or 4.
// One shared multiplier, nine products.
// Depends on icvh_pkg.
module icvh_orient #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [3*COORD_BITS-1:0]       a,
  input  logic [3*COORD_BITS-1:0]       b,
  input  logic [3*COORD_BITS-1:0]       c,
  input  logic [3*(COORD_BITS+2)-1:0]   p,
  input  logic                          k4,
  output icvh_pkg::orient_stat_t        stat
);
  import icvh_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int PW = C + 2;
  localparam int DW = C + 1;
  localparam int QW = C + 4;
  localparam int NW = 2 * C + 3;
  localparam int MW = NW + QW;
  localparam int AW = MW + 2;
  localparam logic [3:0] LAST_STEP = 4'd10;

  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [QW-1:0] q_r  [3];
  logic signed [NW-1:0] n_r  [3];
  logic signed [MW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic [3:0]           step_r;
  logic                 busy_r;

  logic signed [DW-1:0] d1_in [3];
  logic signed [DW-1:0] d2_in [3];
  logic signed [QW-1:0] q_in  [3];
  logic signed [NW-1:0] opa;
  logic signed [QW-1:0] opb;
  logic signed [MW-1:0] prod_nxt;

  always_comb begin
    logic signed [C-1:0]  av;
    logic signed [C-1:0]  bv;
    logic signed [C-1:0]  cv;
    logic signed [PW-1:0] pv;
    for (int k = 0; k < 3; k++) begin
      av = $signed(a[k*C +: C]);
      bv = $signed(b[k*C +: C]);
      cv = $signed(c[k*C +: C]);
      pv = $signed(p[k*PW +: PW]);
      d1_in[k] = DW'(bv) - DW'(av);
      d2_in[k] = DW'(cv) - DW'(av);
      q_in[k]  = k4 ? (QW'(pv) - (QW'(av) <<< 2)) : (QW'(pv) - QW'(av));
    end
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (step_r)
      4'd0: begin opa = NW'(d1_r[1]); opb = QW'(d2_r[2]); end
      4'd1: begin opa = NW'(d1_r[2]); opb = QW'(d2_r[1]); end
      4'd2: begin opa = NW'(d1_r[2]); opb = QW'(d2_r[0]); end
      4'd3: begin opa = NW'(d1_r[0]); opb = QW'(d2_r[2]); end
      4'd4: begin opa = NW'(d1_r[0]); opb = QW'(d2_r[1]); end
      4'd5: begin opa = NW'(d1_r[1]); opb = QW'(d2_r[0]); end
      4'd6: begin opa = n_r[0]; opb = q_r[0]; end
      4'd7: begin opa = n_r[1]; opb = q_r[1]; end
      4'd8: begin opa = n_r[2]; opb = q_r[2]; end
      default: begin opa = '0; opb = '0; end
    endcase
    prod_nxt = MW'(opa) * MW'(opb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 4'd1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (start) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= d1_in[k];
        d2_r[k] <= d2_in[k];
        q_r[k]  <= q_in[k];
        n_r[k]  <= '0;
      end
      acc_r <= '0;
    end else begin
      case (step_r)
        4'd1: n_r[0] <= n_r[0] + NW'(prod_r);
        4'd2: n_r[0] <= n_r[0] - NW'(prod_r);
        4'd3: n_r[1] <= n_r[1] + NW'(prod_r);
        4'd4: n_r[1] <= n_r[1] - NW'(prod_r);
        4'd5: n_r[2] <= n_r[2] + NW'(prod_r);
        4'd6: n_r[2] <= n_r[2] - NW'(prod_r);
        4'd7, 4'd8, 4'd9: acc_r <= acc_r + AW'(prod_r);
        default: ;
      endcase
    end
  end

  assign stat.done    = busy_r && (step_r == LAST_STEP);
  assign stat.outside = acc_r > 0;

endmodule

// ===== src/icvh_checker.sv =====
// Port-level checks for the convex hull block, attached by bind.
// Depends on icvh_pkg and incremental_convex_hull.
module icvh_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_first_x,
  input logic [COORD_BITS-1:0] out_first_y,
  input logic [COORD_BITS-1:0] out_first_z,
  input logic [COORD_BITS-1:0] out_second_x,
  input logic [COORD_BITS-1:0] out_second_y,
  input logic [COORD_BITS-1:0] out_second_z,
  input logic [COORD_BITS-1:0] out_third_x,
  input logic [COORD_BITS-1:0] out_third_y,
  input logic [COORD_BITS-1:0] out_third_z,
  input logic                  out_last,
  input logic [1:0]            out_status
);
  import icvh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("status word without last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_first_x == '0 && out_first_y == '0 && out_first_z == '0 &&
      out_second_x == '0 && out_second_y == '0 && out_second_z == '0 &&
      out_third_x == '0 && out_third_y == '0 && out_third_z == '0)
    else $error("status word carries vertex data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind incremental_convex_hull icvh_checker #(.COORD_BITS(COORD_BITS)) u_icvh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_word.valid),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .out_first_x  (out_word.first_x),
  .out_first_y  (out_word.first_y),
  .out_first_z  (out_word.first_z),
  .out_second_x (out_word.second_x),
  .out_second_y (out_word.second_y),
  .out_second_z (out_word.second_z),
  .out_third_x  (out_word.third_x),
  .out_third_y  (out_word.third_y),
  .out_third_z  (out_word.third_z),
  .out_last     (out_word.last),
  .out_status   (out_word.status)
);

// ===== tb/incremental_convex_hull_tb.sv =====
// Testbench for incremental_convex_hull: drives commands and points, predicts
// every output word from a behavioral hull model and checks each one in order.
// Depends on icvh_pkg, the icvh_in_if / icvh_out_if interfaces and incremental_convex_hull.
`timescale 1ns / 100ps

module incremental_convex_hull_tb;
  import icvh_pkg::*;

  localparam int  NFACE = 64;
  localparam longint LIMIT = 20_000_000;

  typedef struct { longint c[3]; } vtx_t;
  typedef struct {
    logic [143:0] verts;
    logic         last;
    logic [1:0]   status;
  } face_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycles = 0;
  int mismatches = 0;
  int stall_left = 0;
  int burst_left = 0;

  icvh_in_if  #(.COORD_BITS(16)) in_w();
  icvh_out_if #(.COORD_BITS(16)) out_w();

  incremental_convex_hull #(.MAX_FACES(NFACE), .COORD_BITS(16)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_w), .out_word(out_w)
  );

  face_word_t face_words_due[$];

  vtx_t hull_a[NFACE], hull_b[NFACE], hull_c[NFACE];
  vtx_t gone_a[NFACE], gone_b[NFACE], gone_c[NFACE];
  vtx_t seeds[3];
  vtx_t csum;
  int hull_n = 0;
  int seed_n = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit outside_k(vtx_t a, vtx_t b, vtx_t c, vtx_t p, longint k);
    longint d1[3], d2[3], q[3], n[3];
    longint s;
    for (int i = 0; i < 3; i++) begin
      d1[i] = b.c[i] - a.c[i];
      d2[i] = c.c[i] - a.c[i];
      q[i]  = p.c[i] - k * a.c[i];
    end
    n[0] = d1[1] * d2[2] - d1[2] * d2[1];
    n[1] = d1[2] * d2[0] - d1[0] * d2[2];
    n[2] = d1[0] * d2[1] - d1[1] * d2[0];
    s = n[0] * q[0] + n[1] * q[1] + n[2] * q[2];
    return s > 0;
  endfunction

  function automatic bit same_vtx(vtx_t x, vtx_t y);
    return x.c[0] == y.c[0] && x.c[1] == y.c[1] && x.c[2] == y.c[2];
  endfunction

  function automatic bit on_face(vtx_t p, int f);
    return same_vtx(p, hull_a[f]) || same_vtx(p, hull_b[f]) || same_vtx(p, hull_c[f]);
  endfunction

  function automatic bit append_face(vtx_t p, vtx_t q, vtx_t r);
    if (hull_n >= NFACE) return 1'b0;
    hull_a[hull_n] = p;
    if (outside_k(p, q, r, csum, 4)) begin
      hull_b[hull_n] = r;
      hull_c[hull_n] = q;
    end else begin
      hull_b[hull_n] = q;
      hull_c[hull_n] = r;
    end
    hull_n++;
    return 1'b1;
  endfunction

  function automatic bit grow_hull(vtx_t p);
    int kept, gone;
    bit ok;
    kept = 0;
    gone = 0;
    ok = 1'b1;
    for (int i = 0; i < hull_n; i++) begin
      if (outside_k(hull_a[i], hull_b[i], hull_c[i], p, 1)) begin
        gone_a[gone] = hull_a[i];
        gone_b[gone] = hull_b[i];
        gone_c[gone] = hull_c[i];
        gone++;
      end else begin
        hull_a[kept] = hull_a[i];
        hull_b[kept] = hull_b[i];
        hull_c[kept] = hull_c[i];
        kept++;
      end
    end
    hull_n = kept;
    for (int i = 0; i < gone; i++) begin
      for (int j = 0; j < kept; j++) begin
        vtx_t e1, e2;
        if (on_face(gone_a[i], j) && on_face(gone_b[i], j)) begin
          e1 = gone_a[i]; e2 = gone_b[i];
        end else if (on_face(gone_b[i], j) && on_face(gone_c[i], j)) begin
          e1 = gone_b[i]; e2 = gone_c[i];
        end else if (on_face(gone_c[i], j) && on_face(gone_a[i], j)) begin
          e1 = gone_c[i]; e2 = gone_a[i];
        end else begin
          continue;
        end
        if (!append_face(p, e1, e2)) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [47:0] pack_vtx(vtx_t v);
    logic [15:0] x, y, z;
    x = v.c[0][15:0];
    y = v.c[1][15:0];
    z = v.c[2][15:0];
    return {x, y, z};
  endfunction

  function automatic void push_status(logic [1:0] st);
    face_word_t w;
    w.verts = '0;
    w.last = 1'b1;
    w.status = st;
    face_words_due.insert(face_words_due.size(), w);
  endfunction

  function automatic void predict_hull_word(logic [1:0] func, vtx_t p);
    face_word_t w;
    bit dummy;
    case (func)
      FUNC_CLEAR: begin
        hull_n = 0;
        seed_n = 0;
        csum.c = '{0, 0, 0};
        push_status(ST_OK);
      end
      FUNC_READ: begin
        if (hull_n == 0) begin
          push_status(ST_EMPTY);
        end else begin
          for (int i = 0; i < hull_n; i++) begin
            w.verts = {pack_vtx(hull_a[i]), pack_vtx(hull_b[i]), pack_vtx(hull_c[i])};
            w.last = (i == hull_n - 1);
            w.status = ST_OK;
            face_words_due.insert(face_words_due.size(), w);
          end
        end
      end
      FUNC_NOP: push_status(ST_OK);
      default: begin
        if (seed_n < 3) begin
          seeds[seed_n] = p;
          seed_n++;
          push_status(ST_SEED);
        end else if (seed_n == 3) begin
          for (int i = 0; i < 3; i++)
            csum.c[i] = seeds[0].c[i] + seeds[1].c[i] + seeds[2].c[i] + p.c[i];
          hull_n = 0;
          dummy = append_face(seeds[0], seeds[1], seeds[2]);
          dummy = append_face(seeds[1], seeds[2], p);
          dummy = append_face(seeds[2], p, seeds[0]);
          dummy = append_face(p, seeds[0], seeds[1]);
          seed_n = 4;
          push_status(ST_OK);
        end else begin
          push_status(grow_hull(p) ? ST_OK : ST_OVF);
        end
      end
    endcase
  endfunction

  task automatic send_word(logic [1:0] func, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int r, gap;
    vtx_t p;
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid   <= 1'b1;
    in_w.func    <= func;
    in_w.point_x <= x;
    in_w.point_y <= y;
    in_w.point_z <= z;
    do @(posedge clk); while (!in_w.ready);
    p.c[0] = longint'($signed(x));
    p.c[1] = longint'($signed(y));
    p.c[2] = longint'($signed(z));
    predict_hull_word(func, p);
  endtask

  task automatic send_bowl_point(bit flip);
    int x, y, z;
    x = $urandom_range(0, 200) - 100;
    y = $urandom_range(0, 200) - 100;
    z = x * x + y * y - 10000;
    if ($urandom_range(0, 9) == 0) z = z + $urandom_range(1, 5000);
    if (flip) z = -z;
    send_word(FUNC_ADD, 16'(x), 16'(y), 16'(z));
  endtask

  // receive side: random backpressure with quiet stretches
  always @(posedge clk) begin
    int r;
    if (rst_n) begin
      if (burst_left > 0) begin
        out_w.ready <= 1'b1;
        burst_left <= burst_left - 1;
      end else if (stall_left > 0) begin
        out_w.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) stall_left <= $urandom_range(10, 60);
        else if (r < 15) stall_left <= $urandom_range(1, 3);
        else if (r < 17) burst_left <= $urandom_range(50, 300);
        out_w.ready <= (r >= 15);
      end
      if (out_w.valid && out_w.ready) begin
        logic [143:0] got;
        got = {out_w.first_x, out_w.first_y, out_w.first_z,
               out_w.second_x, out_w.second_y, out_w.second_z,
               out_w.third_x, out_w.third_y, out_w.third_z};
        if (face_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: verts %h last %b status %0d",
                                         got, out_w.last, out_w.status);
        end else begin
          face_word_t w;
          w = face_words_due.pop_front();
          if (got !== w.verts || out_w.last !== w.last || out_w.status !== w.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp verts %h last %b status %0d", w.verts, w.last, w.status);
              $display("          got verts %h last %b status %0d", got, out_w.last,
                       out_w.status);
            end
          end
        end
      end
    end
  end

  task automatic test_status_commands();
    send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
    send_word(FUNC_NOP, 16'hffff, 16'hffff, 16'hffff);
    send_word(FUNC_ADD, 16'd256, 16'd0, 16'd0);
    send_word(FUNC_ADD, 16'd0, 16'd256, 16'd0);
    send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
    send_word(FUNC_CLEAR, 16'h0, 16'h0, 16'h0);
    send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_extremes();
    send_word(FUNC_ADD, 16'h8000, 16'h8000, 16'h8000);
    send_word(FUNC_ADD, 16'h7fff, 16'h8000, 16'h8000);
    send_word(FUNC_ADD, 16'h8000, 16'h7fff, 16'h8000);
    send_word(FUNC_ADD, 16'h8000, 16'h8000, 16'h7fff);
    send_word(FUNC_ADD, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(FUNC_ADD, 16'h0, 16'h0, 16'h0);
    send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
    send_word(FUNC_CLEAR, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_degenerate();
    send_word(FUNC_ADD, 16'd0, 16'd0, 16'd0);
    send_word(FUNC_ADD, 16'd100, 16'd0, 16'd0);
    send_word(FUNC_ADD, 16'd0, 16'd100, 16'd0);
    send_word(FUNC_ADD, 16'd100, 16'd100, 16'd0);
    send_word(FUNC_ADD, 16'd50, 16'd50, 16'd0);
    send_word(FUNC_ADD, 16'd100, 16'd0, 16'd0);
    send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
    send_word(FUNC_CLEAR, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_random_hulls(int budget);
    int sent;
    int npts;
    bit flip;
    sent = 0;
    while (sent < budget) begin
      send_word(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
      flip = $urandom_range(0, 1);
      npts = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 14);
      for (int i = 0; i < npts; i++) begin
        send_bowl_point(flip);
        if ($urandom_range(0, 7) == 0) send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
      end
      send_word(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom));
      sent += npts + 2;
    end
  endtask

  task automatic test_noise(int count);
    logic [1:0] f;
    for (int i = 0; i < count; i++) begin
      f = 2'($urandom_range(0, 9) < 6 ? FUNC_ADD : $urandom_range(0, 3));
      send_word(f, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    send_word(FUNC_READ, 16'h0, 16'h0, 16'h0);
  endtask

  initial begin
    in_w.valid   = 1'b0;
    in_w.func    = FUNC_NOP;
    in_w.point_x = '0;
    in_w.point_y = '0;
    in_w.point_z = '0;
    out_w.ready  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_status_commands();
    test_extremes();
    test_degenerate();
    test_random_hulls(330);
    test_noise(60);
    @(posedge clk);
    in_w.valid <= 1'b0;
    while (face_words_due.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && face_words_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/icvh_pkg.sv
src/icvh_if.sv
src/icvh_orient.sv
src/incremental_convex_hull.sv
src/icvh_checker.sv
tb/incremental_convex_hull_tb.sv
